[rtl/core/poi_pkg.sv]
package poi_pkg;

  localparam int CordicSteps = 14;
  localparam int IterW = $clog2(CordicSteps);

  localparam int RateW = 16;
  localparam int TimeW = 16;
  localparam int PosW  = 32;
  localparam int HeadW = 16;
  localparam int QuatW = 16;
  localparam int TrigW = 32;
  localparam int XyW   = 33;
  localparam int DistW = 33;
  localparam int MulAW = 34;
  localparam int MulBW = 18;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 64;

  localparam int       PiQ13     = 25736;
  localparam int       TwoPiQ13  = 51472;
  localparam longint   PiQ30     = 64'd3373259426;
  localparam longint   HalfPiQ30 = 64'd1686629713;
  localparam longint   GainQ30   = 64'd652032874;
  localparam longint   OneQ30    = 64'd1073741824;

  typedef enum logic [3:0] {
    SIdle,
    SMulRate,
    SHead,
    SSetup,
    SCordic,
    SMulCl,
    SMulCh,
    SMulSl,
    SMulSh,
    SAccY,
    SUpdY,
    SFinish
  } poi_state_e;

  typedef struct packed {
    logic                    start;
    logic signed [TrigW-1:0] angle;
  } cor_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [TrigW-1:0] cos_v;
    logic signed [TrigW-1:0] sin_v;
  } cor_rsp_t;

  function automatic logic signed [TrigW-1:0] atan_q30(input logic [3:0] idx);
    logic signed [TrigW-1:0] r;
    case (idx)
      4'd0:    r = 32'sd843314856;
      4'd1:    r = 32'sd497837829;
      4'd2:    r = 32'sd263043836;
      4'd3:    r = 32'sd133525158;
      4'd4:    r = 32'sd67021686;
      4'd5:    r = 32'sd33543515;
      4'd6:    r = 32'sd16775850;
      4'd7:    r = 32'sd8388437;
      4'd8:    r = 32'sd4194282;
      4'd9:    r = 32'sd2097149;
      4'd10:   r = 32'sd1048575;
      4'd11:   r = 32'sd524287;
      4'd12:   r = 32'sd262143;
      4'd13:   r = 32'sd131071;
      4'd14:   r = 32'sd65535;
      default: r = 32'sd32767;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/poi_mul.sv]
module poi_mul import poi_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [ProdW-1:0] prod_o
);

  logic signed [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

[rtl/core/poi_cordic.sv]
module poi_cordic import poi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cor_req_t req_i,
  output cor_rsp_t rsp_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [IterW-1:0]        iter_q, iter_d;
  logic signed [XyW-1:0]   x_q, x_d, y_q, y_d, dx, dy;
  logic signed [TrigW-1:0] z_q, z_d, at;

  function automatic logic signed [TrigW-1:0] clamp_one(input logic signed [XyW-1:0] v);
    logic signed [TrigW-1:0] r;
    if (v > XyW'(OneQ30)) begin
      r = TrigW'(OneQ30);
    end else if (v < -XyW'(OneQ30)) begin
      r = -TrigW'(OneQ30);
    end else begin
      r = TrigW'(v);
    end
    return r;
  endfunction

  assign dx = y_q >>> iter_q;
  assign dy = x_q >>> iter_q;
  assign at = atan_q30(4'(iter_q));

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      iter_d = '0;
      x_d    = XyW'(GainQ30);
      y_d    = '0;
      z_d    = req_i.angle;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      if (iter_q == IterW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        iter_d = iter_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = clamp_one(x_q);
  assign rsp_o.sin_v = clamp_one(y_q);

  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("CORDIC busy and done at once");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("CORDIC started while busy");

endmodule

[rtl/core/planar_odometry_integrator.sv]
// Items are processed one at a time: each takes two passes of the shared CORDIC unit,
// run back to back, and the four position multiplies overlap the second pass.
// A new item is accepted while the previous result waits in the output register.
// Reset (asynchronous, active low) clears heading and position, and the first item
// after reset is integrated with zero elapsed time.
module planar_odometry_integrator import poi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [RateW-1:0] yaw_rate_i,
  input  logic signed [RateW-1:0] forward_speed_i,
  input  logic [TimeW-1:0]        elapsed_time_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [PosW-1:0]  pos_x_o,
  output logic signed [PosW-1:0]  pos_y_o,
  output logic signed [HeadW-1:0] heading_o,
  output logic signed [QuatW-1:0] quat_z_o,
  output logic signed [QuatW-1:0] quat_w_o
);

  poi_state_e state_q, state_d;

  logic                    first_q, first_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [RateW-1:0] rate_q, rate_d, speed_q, speed_d;
  logic [TimeW-1:0]        dt_q, dt_d;
  logic signed [HeadW-1:0] heading_q, heading_d;
  logic signed [DistW-1:0] dist_q, dist_d;
  logic                    neg_q, neg_d;
  logic signed [TrigW-1:0] c_q, c_d, s_q, s_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [PosW-1:0]  x_q, x_d, y_q, y_d;
  logic signed [PosW-1:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic signed [HeadW-1:0] head_out_q, head_out_d;
  logic signed [QuatW-1:0] qz_q, qz_d, qw_q, qw_d;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_prod;
  cor_req_t                cor_req;
  cor_rsp_t                cor_rsp;

  logic signed [33:0]      rd_sum;
  logic signed [19:0]      head_sum;
  logic signed [HeadW-1:0] head_wrapped;
  logic signed [33:0]      ang_full;
  logic signed [TrigW-1:0] ang_red;
  logic                    ang_neg;
  logic signed [AccW-1:0]  rnd_sum;
  logic signed [PosW-1:0]  pos_step;
  logic signed [TrigW-1:0] c_adj, s_adj;

  function automatic logic signed [HeadW-1:0] wrap_pi(input logic signed [19:0] h);
    logic signed [19:0] v;
    v = h;
    if (v > 20'(PiQ13)) v = v - 20'(TwoPiQ13);
    if (v > 20'(PiQ13)) v = v - 20'(TwoPiQ13);
    if (v <= -20'(PiQ13)) v = v + 20'(TwoPiQ13);
    if (v <= -20'(PiQ13)) v = v + 20'(TwoPiQ13);
    return HeadW'(v);
  endfunction

  function automatic logic signed [QuatW-1:0] to_q14(input logic signed [TrigW-1:0] v);
    logic signed [TrigW:0] t;
    logic signed [16:0]    q;
    logic signed [QuatW-1:0] r;
    t = (TrigW + 1)'(v) + 33'sd32768;
    q = 17'(t >>> 16);
    if (q > 17'sd16384) begin
      r = 16'sd16384;
    end else if (q < -17'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = QuatW'(q);
    end
    return r;
  endfunction

  poi_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_prod)
  );

  poi_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  // Heading step rounded from Q4.28 to Q3.13, then wrapped into (-pi, pi].
  assign rd_sum       = 34'($signed(mul_prod[32:0])) + 34'sd16384;
  assign head_sum     = 20'(heading_q) + 20'(rd_sum >>> 15);
  assign head_wrapped = wrap_pi(head_sum);

  // Fold the full heading into the CORDIC range; sin and cos then flip sign.
  assign ang_full = 34'(heading_q) <<< 17;
  always_comb begin
    ang_neg = 1'b0;
    ang_red = TrigW'(ang_full);
    if (ang_full > 34'(HalfPiQ30)) begin
      ang_neg = 1'b1;
      ang_red = TrigW'(ang_full - 34'(PiQ30));
    end else if (ang_full < -34'(HalfPiQ30)) begin
      ang_neg = 1'b1;
      ang_red = TrigW'(ang_full + 34'(PiQ30));
    end
  end

  assign c_adj    = neg_q ? -cor_rsp.cos_v : cor_rsp.cos_v;
  assign s_adj    = neg_q ? -cor_rsp.sin_v : cor_rsp.sin_v;
  assign rnd_sum  = acc_q + (64'sd1 <<< 41);
  assign pos_step = PosW'(rnd_sum >>> 42);

  always_comb begin
    state_d     = state_q;
    first_d     = first_q;
    out_valid_d = out_valid_q && !out_ready_i;
    rate_d      = rate_q;
    speed_d     = speed_q;
    dt_d        = dt_q;
    heading_d   = heading_q;
    dist_d      = dist_q;
    neg_d       = neg_q;
    c_d         = c_q;
    s_d         = s_q;
    acc_d       = acc_q;
    x_d         = x_q;
    y_d         = y_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    head_out_d  = head_out_q;
    qz_d        = qz_q;
    qw_d        = qw_q;
    mul_a       = '0;
    mul_b       = '0;
    cor_req     = '0;
    in_ready_o  = 1'b0;

    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          rate_d  = yaw_rate_i;
          speed_d = forward_speed_i;
          dt_d    = first_q ? '0 : elapsed_time_i;
          first_d = 1'b0;
          state_d = SMulRate;
        end
      end
      SMulRate: begin
        mul_a   = MulAW'(rate_q);
        mul_b   = {2'b00, dt_q};
        state_d = SHead;
      end
      SHead: begin
        heading_d = head_wrapped;
        mul_a     = MulAW'(speed_q);
        mul_b     = {2'b00, dt_q};
        state_d   = SSetup;
      end
      SSetup: begin
        dist_d        = mul_prod[DistW-1:0];
        neg_d         = ang_neg;
        cor_req.start = 1'b1;
        cor_req.angle = ang_red;
        state_d       = SCordic;
      end
      SCordic: begin
        if (cor_rsp.done) begin
          c_d           = c_adj;
          s_d           = s_adj;
          cor_req.start = 1'b1;
          cor_req.angle = TrigW'(heading_q) <<< 16;
          state_d       = SMulCl;
        end
      end
      SMulCl: begin
        mul_a   = MulAW'(dist_q);
        mul_b   = {2'b00, c_q[15:0]};
        state_d = SMulCh;
      end
      SMulCh: begin
        acc_d   = AccW'(mul_prod);
        mul_a   = MulAW'(dist_q);
        mul_b   = MulBW'($signed(c_q[31:16]));
        state_d = SMulSl;
      end
      SMulSl: begin
        acc_d   = acc_q + (AccW'(mul_prod) <<< 16);
        mul_a   = MulAW'(dist_q);
        mul_b   = {2'b00, s_q[15:0]};
        state_d = SMulSh;
      end
      SMulSh: begin
        x_d     = x_q + pos_step;
        acc_d   = AccW'(mul_prod);
        mul_a   = MulAW'(dist_q);
        mul_b   = MulBW'($signed(s_q[31:16]));
        state_d = SAccY;
      end
      SAccY: begin
        acc_d   = acc_q + (AccW'(mul_prod) <<< 16);
        state_d = SUpdY;
      end
      SUpdY: begin
        y_d     = y_q + pos_step;
        state_d = SFinish;
      end
      SFinish: begin
        if (cor_rsp.done && (!out_valid_q || out_ready_i)) begin
          pos_x_d     = x_q;
          pos_y_d     = y_q;
          head_out_d  = heading_q;
          qz_d        = to_q14(cor_rsp.sin_v);
          qw_d        = to_q14(cor_rsp.cos_v);
          out_valid_d = 1'b1;
          state_d     = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
      heading_q   <= '0;
      x_q         <= '0;
      y_q         <= '0;
    end else begin
      state_q     <= state_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      heading_q   <= heading_d;
      x_q         <= x_d;
      y_q         <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q     <= rate_d;
    speed_q    <= speed_d;
    dt_q       <= dt_d;
    dist_q     <= dist_d;
    neg_q      <= neg_d;
    c_q        <= c_d;
    s_q        <= s_d;
    acc_q      <= acc_d;
    pos_x_q    <= pos_x_d;
    pos_y_q    <= pos_y_d;
    head_out_q <= head_out_d;
    qz_q       <= qz_d;
    qw_q       <= qw_d;
  end

  assign out_valid_o = out_valid_q;
  assign pos_x_o     = pos_x_q;
  assign pos_y_o     = pos_y_q;
  assign heading_o   = head_out_q;
  assign quat_z_o    = qz_q;
  assign quat_w_o    = qw_q;

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (heading_q <= 16'(PiQ13)) && (heading_q > -16'(PiQ13)))
    else $error("Stored heading outside the wrapped range");

  a_first_zero_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && first_q) |=> (dt_q == '0))
    else $error("First item after reset did not use zero elapsed time");

  a_quat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (quat_z_o <= 16'sd16384) && (quat_z_o >= -16'sd16384) &&
                    (quat_w_o <= 16'sd16384) && (quat_w_o >= -16'sd16384))
    else $error("Quaternion component out of range");

endmodule

[sim/planar_odometry_integrator_tb.sv]
`timescale 1ns / 100ps

module planar_odometry_integrator_tb;
  import poi_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 740;
  localparam int WrapRunItems = 40;

  localparam longint AtanQ30 [0:15] = '{
    843314856, 497837829, 263043836, 133525158,
    67021686, 33543515, 16775850, 8388437,
    4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  typedef struct packed {
    logic signed [RateW-1:0] rate;
    logic signed [RateW-1:0] speed;
    logic [TimeW-1:0]        dt;
  } motion_t;

  typedef struct packed {
    logic signed [PosW-1:0]  x;
    logic signed [PosW-1:0]  y;
    logic signed [HeadW-1:0] hdg;
    logic signed [QuatW-1:0] qz;
    logic signed [QuatW-1:0] qw;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic signed [RateW-1:0] yaw_rate = '0;
  logic signed [RateW-1:0] forward_speed = '0;
  logic [TimeW-1:0] elapsed_time = '0;

  logic in_ready;
  logic out_valid;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic signed [HeadW-1:0] heading;
  logic signed [QuatW-1:0] quat_z;
  logic signed [QuatW-1:0] quat_w;

  motion_t motion_q [$];
  pose_t pose_q [$];

  longint head_q13 = 0;
  logic [PosW-1:0] x_pos = '0;
  logic [PosW-1:0] y_pos = '0;
  bit first_item = 1'b1;

  int n_mismatch = 0;
  int n_items = 0;
  int n_recv = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  motion_t next_motion;
  pose_t want;

  planar_odometry_integrator u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .yaw_rate_i     (yaw_rate),
    .forward_speed_i(forward_speed),
    .elapsed_time_i (elapsed_time),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pos_x_o        (pos_x),
    .pos_y_o        (pos_y),
    .heading_o      (heading),
    .quat_z_o       (quat_z),
    .quat_w_o       (quat_w)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint sat(input longint v, input longint lim);
    return (v < -lim) ? -lim : ((v > lim) ? lim : v);
  endfunction

  function automatic void rotate_vec(input longint ang, output longint c, output longint s);
    longint vx, vy, vz, dx, dy;
    int i;
    vx = GainQ30;
    vy = 0;
    vz = ang;
    for (i = 0; i < CordicSteps && i < 16; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vz >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        vz = vz - AtanQ30[i];
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        vz = vz + AtanQ30[i];
      end
    end
    c = sat(vx, OneQ30);
    s = sat(vy, OneQ30);
  endfunction

  function automatic pose_t integrate(input logic signed [RateW-1:0] rate,
                                      input logic signed [RateW-1:0] speed,
                                      input logic [TimeW-1:0] dt_raw);
    longint dt, h, ang, c, s, hc, hs, travel, dx, dy;
    bit flip;
    pose_t p;
    dt = first_item ? longint'(0) : longint'(dt_raw);
    first_item = 1'b0;
    h = head_q13 + ((longint'(rate) * dt + 16384) >>> 15);
    while (h > PiQ13) h = h - TwoPiQ13;
    while (h <= -PiQ13) h = h + TwoPiQ13;
    head_q13 = h;

    ang = h * 131072;
    flip = 1'b0;
    if (ang > HalfPiQ30) begin
      ang = ang - PiQ30;
      flip = 1'b1;
    end else if (ang < -HalfPiQ30) begin
      ang = ang + PiQ30;
      flip = 1'b1;
    end
    rotate_vec(ang, c, s);
    if (flip) begin
      c = -c;
      s = -s;
    end

    travel = longint'(speed) * dt;
    dx = (travel * c + (longint'(1) <<< 41)) >>> 42;
    dy = (travel * s + (longint'(1) <<< 41)) >>> 42;
    x_pos = x_pos + dx[PosW-1:0];
    y_pos = y_pos + dy[PosW-1:0];

    rotate_vec(h * 65536, hc, hs);
    hs = sat((hs + 32768) >>> 16, 16384);
    hc = sat((hc + 32768) >>> 16, 16384);
    p.x = x_pos;
    p.y = y_pos;
    p.hdg = h[HeadW-1:0];
    p.qz = hs[QuatW-1:0];
    p.qw = hc[QuatW-1:0];
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    if (send_calm) return 0;
    r = $urandom_range(9);
    if (r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_motion(input int r, input int s, input int d);
    motion_t m;
    m.rate = r[RateW-1:0];
    m.speed = s[RateW-1:0];
    m.dt = d[TimeW-1:0];
    motion_q.push_back(m);
  endtask

  task automatic report_pose(input string what, input pose_t p);
    n_mismatch++;
    if (n_mismatch <= 10) begin
      $display("%0t %s: want x=%h y=%h h=%h qz=%h qw=%h, got x=%h y=%h h=%h qz=%h qw=%h",
               $realtime, what, p.x, p.y, p.hdg, p.qz, p.qw,
               pos_x, pos_y, heading, quat_z, quat_w);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid && send_gap > 0) send_gap--;
      if (in_valid && in_ready) begin
        pose_q.push_back(integrate(yaw_rate, forward_speed, elapsed_time));
        if ($urandom_range(49) == 0) send_calm = !send_calm;
        send_gap = pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (send_gap == 0 && motion_q.size() > 0) begin
          next_motion = motion_q.pop_front();
          yaw_rate <= next_motion.rate;
          forward_speed <= next_motion.speed;
          elapsed_time <= next_motion.dt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_recv++;
        if (pose_q.size() == 0) begin
          want = '0;
          report_pose("unexpected result", want);
        end else begin
          want = pose_q.pop_front();
          if (want.x !== pos_x || want.y !== pos_y || want.hdg !== heading ||
              want.qz !== quat_z || want.qw !== quat_w) begin
            report_pose("pose mismatch", want);
          end
        end
      end
      if ($urandom_range(199) == 0) recv_calm = !recv_calm;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (recv_calm) begin
        out_ready <= 1'b1;
      end else begin
        case ($urandom_range(9))
          0, 1, 2: begin
            stall_left = $urandom_range(0, 3);
            out_ready <= 1'b0;
          end
          3: begin
            stall_left = $urandom_range(15, 60);
            out_ready <= 1'b0;
          end
          default: out_ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    push_motion(32767, 32767, 65535);
    push_motion(-25736, 1000, 32768);
    push_motion(25736, -32768, 32768);
    repeat (WrapRunItems) push_motion(0, 32767, 65535);
    push_motion(12868, 20000, 32768);
    push_motion(1, -20000, 32768);
    push_motion(-25737, 32767, 32768);
    push_motion(-1, -32768, 32768);
    push_motion(12869, 5, 32768);
    push_motion(32767, 32767, 65535);
    push_motion(-32768, -32768, 65535);
    push_motion(-32768, 32767, 0);
    push_motion(0, 0, 65535);
    push_motion(1, 1, 1);
    push_motion(-1, -1, 16385);
    push_motion(-1, 32767, 16384);
    repeat (RandomItems) begin
      case ($urandom_range(3))
        0: push_motion($urandom, $urandom, $urandom);
        1: push_motion($urandom_range(0, 1023) - 512, $urandom, $urandom);
        2: push_motion($urandom, $urandom, $urandom_range(0, 255));
        default: push_motion($urandom, $urandom, $urandom_range(1) ? 65535 : 0);
      endcase
    end
    n_items = motion_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_recv >= n_items);
    repeat (DrainCycles) @(posedge clk);
    if (n_mismatch == 0 && pose_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
